// File: src/dorf_pkg.sv
// Shared definitions for the drop-oldest ring FIFO.
// Command and status codes, register map and parameter defaults.
// No dependencies.
package dorf_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int WORD_WIDTH_DEFAULT = 32;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [0:0] REG_CAPACITY = 1'b0;

   localparam int CAP_RESET = 16;

   localparam logic [1:0] CMD_PUSH  = 2'd0;
   localparam logic [1:0] CMD_POP   = 2'd1;
   localparam logic [1:0] CMD_CLOSE = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_DROPPED = 2'd1;
   localparam logic [1:0] STAT_CLOSED  = 2'd2;
   localparam logic [1:0] STAT_EMPTY   = 2'd3;

endpackage

// File: src/drop_oldest_ring_fifo.sv
// Top level of the drop-oldest ring FIFO: command decode, pointers, entry memory.
// Depends on dorf_pkg and dorf_csr.
//
// Each req beat carries one command (push, pop, close) and yields exactly one rsp
// beat with status, popped word and occupancy. A beat is taken every cycle while
// the rsp side keeps up; its result is loaded into the output registers on
// acceptance, the word from the single registered read port of the entry memory. The
// entry memory has one write port (push at the tail) and one registered read port
// (pop at the head); it needs no clearing pass because only pushed entries are read.
// A push onto a full FIFO drops the oldest entry first. Writing capacity_in_use
// (clamped to 1..DEPTH) empties the FIFO but keeps the closed flag; write it only
// while the block is idle.
module drop_oldest_ring_fifo #(
   parameter int DEPTH      = dorf_pkg::DEPTH_DEFAULT,
   parameter int WORD_WIDTH = dorf_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              req_tvalid,
   output logic                                              req_tready,
   // item_value
   input  logic [((WORD_WIDTH+7)/8)*8-1:0]                   req_tdata,
   // command
   input  logic [1:0]                                        req_tuser,
   output logic                                              rsp_tvalid,
   input  logic                                              rsp_tready,
   // item_out, occupancy
   output logic [((WORD_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0]   rsp_tdata,
   // status
   output logic [1:0]                                        rsp_tuser,
   input  logic                                              csr_psel,
   input  logic                                              csr_penable,
   input  logic                                              csr_pwrite,
   input  logic [dorf_pkg::CSR_ADDR_W-1:0]                   csr_paddr,
   input  logic [dorf_pkg::CSR_DATA_W-1:0]                   csr_pwdata,
   output logic [dorf_pkg::CSR_DATA_W-1:0]                   csr_prdata,
   output logic                                              csr_pready
);

   localparam int CNT_W = $clog2(DEPTH+1);
   localparam int IDX_W = $clog2(DEPTH);

   logic [CNT_W-1:0]      capacity;
   logic                  cap_written;

   logic [WORD_WIDTH-1:0] mem [DEPTH];

   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  closed_ff, closed_in;

   logic                  rsp_valid_ff;
   logic [1:0]            status_ff, status_in;
   logic [CNT_W-1:0]      occ_ff;
   logic                  popped_ff, popped_in;
   logic [WORD_WIDTH-1:0] rd_data_ff;

   logic                  accept;
   logic                  mem_we;
   logic [1:0]            cmd;
   logic [WORD_WIDTH-1:0] word;
   logic [IDX_W-1:0]      head_adv;
   logic [IDX_W-1:0]      tail_adv;

   dorf_csr #(
      .DEPTH(DEPTH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity),
      .cap_written (cap_written)
   );

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] cap);
      logic [CNT_W:0] n;
      n = {{(CNT_W+1-IDX_W){1'b0}}, idx} + (CNT_W+1)'(1);
      return (n >= {1'b0, cap}) ? '0 : n[IDX_W-1:0];
   endfunction

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = req_tuser;
   assign word       = req_tdata[WORD_WIDTH-1:0];
   assign head_adv   = ring_next(head_ff, capacity);
   assign tail_adv   = ring_next(tail_ff, capacity);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      closed_in = closed_ff;
      status_in = dorf_pkg::STAT_OK;
      popped_in = 1'b0;
      mem_we    = 1'b0;
      unique case (cmd)
         dorf_pkg::CMD_PUSH: begin
            if (closed_ff) begin
               status_in = dorf_pkg::STAT_CLOSED;
            end else begin
               mem_we  = 1'b1;
               tail_in = tail_adv;
               if (count_ff >= capacity) begin
                  head_in   = head_adv;
                  status_in = dorf_pkg::STAT_DROPPED;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         dorf_pkg::CMD_POP: begin
            if (count_ff == '0) begin
               status_in = closed_ff ? dorf_pkg::STAT_CLOSED : dorf_pkg::STAT_EMPTY;
            end else begin
               popped_in = 1'b1;
               head_in   = head_adv;
               count_in  = count_ff - CNT_W'(1);
            end
         end
         dorf_pkg::CMD_CLOSE: begin
            closed_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cap_written) begin
            head_ff  <= '0;
            tail_ff  <= '0;
            count_ff <= '0;
         end else if (accept) begin
            head_ff   <= head_in;
            tail_ff   <= tail_in;
            count_ff  <= count_in;
            closed_ff <= closed_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         occ_ff    <= count_in;
         popped_ff <= popped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && mem_we) begin
         mem[tail_ff] <= word;
      end
      if (accept) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[WORD_WIDTH-1:0]     = popped_ff ? rd_data_ff : '0;
      rsp_tdata[WORD_WIDTH +: CNT_W] = occ_ff;
   end

endmodule

// File: src/dorf_csr.sv
// Configuration register block of the drop-oldest ring FIFO.
// Holds the clamped capacity_in_use register and flags each write.
// Depends on dorf_pkg.
module dorf_csr #(
   parameter int DEPTH = dorf_pkg::DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dorf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dorf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dorf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output logic [$clog2(DEPTH+1)-1:0]       capacity,
   output logic                             cap_written
);

   localparam int CNT_W = $clog2(DEPTH+1);
   localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CAP_ONE = CNT_W'(1);
   localparam logic [CNT_W-1:0] CAP_RST =
      (dorf_pkg::CAP_RESET > DEPTH) ? CAP_MAX : CNT_W'(dorf_pkg::CAP_RESET);

   logic [CNT_W-1:0] capacity_ff;
   logic [CNT_W-1:0] capacity_in;
   logic [CNT_W-1:0] wr_value;
   logic             wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel & csr_penable & csr_pwrite & csr_pready &
                       (csr_paddr[2] == dorf_pkg::REG_CAPACITY);
   assign wr_value   = csr_pwdata[CNT_W-1:0];

   always_comb begin
      priority if (wr_value == '0) begin
         capacity_in = CAP_ONE;
      end else if (wr_value > CAP_MAX) begin
         capacity_in = CAP_MAX;
      end else begin
         capacity_in = wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RST;
      end else if (wr_hit) begin
         capacity_ff <= capacity_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == dorf_pkg::REG_CAPACITY) begin
         csr_prdata[CNT_W-1:0] = capacity_ff;
      end
   end

   assign capacity    = capacity_ff;
   assign cap_written = wr_hit;

endmodule

// File: tb/dorf_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the drop-oldest ring FIFO: tracks csr writes and req beats,
// predicts each rsp beat and compares it field by field. Depends on dorf_pkg.
module dorf_checker #(
   parameter int DEPTH  = dorf_pkg::DEPTH_DEFAULT,
   parameter int WORD_W = dorf_pkg::WORD_WIDTH_DEFAULT,
   parameter int OCC_W  = $clog2(DEPTH + 1),
   parameter int REQ_W  = ((WORD_W + 7) / 8) * 8,
   parameter int RSP_W  = ((WORD_W + OCC_W + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // item_value
   input  logic [REQ_W-1:0]                  req_tdata,
   // command
   input  logic [1:0]                        req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // item_out, occupancy
   input  logic [RSP_W-1:0]                  rsp_tdata,
   // status
   input  logic [1:0]                        rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dorf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dorf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  logic                              csr_pready,
   output int unsigned                       outstanding,
   output int unsigned                       mismatches
);

   localparam int ADDR_W = dorf_pkg::CSR_ADDR_W;
   localparam logic [ADDR_W-1:0] CAP_ADDR = ADDR_W'(4 * dorf_pkg::REG_CAPACITY);

   typedef struct packed {
      logic [1:0]        status;
      logic [WORD_W-1:0] word;
      logic [OCC_W-1:0]  occupancy;
   } fifo_reply_type;

   logic [WORD_W-1:0] ring [DEPTH];
   int unsigned       head_ptr;
   int unsigned       tail_ptr;
   int unsigned       fill;
   int unsigned       cap_limit;
   bit                is_closed;
   fifo_reply_type    pending_replies [$];
   fifo_reply_type    want;
   fifo_reply_type    got;

   function automatic int unsigned clamp_cap(logic [dorf_pkg::CSR_DATA_W-1:0] value);
      int unsigned v;
      v = value[4:0];
      if (v < 1) return 1;
      if (v > DEPTH) return DEPTH;
      return v;
   endfunction

   function automatic int unsigned next_slot(int unsigned idx);
      return (idx + 1 >= cap_limit) ? 0 : idx + 1;
   endfunction

   function automatic fifo_reply_type apply_command(logic [1:0] cmd,
                                                    logic [WORD_W-1:0] value);
      fifo_reply_type r;
      r.status = dorf_pkg::STAT_OK;
      r.word   = '0;
      case (cmd)
         dorf_pkg::CMD_PUSH: begin
            if (is_closed) begin
               r.status = dorf_pkg::STAT_CLOSED;
            end else begin
               if (fill >= cap_limit) begin
                  head_ptr = next_slot(head_ptr);
                  fill--;
                  r.status = dorf_pkg::STAT_DROPPED;
               end
               ring[tail_ptr] = value;
               tail_ptr = next_slot(tail_ptr);
               fill++;
            end
         end
         dorf_pkg::CMD_POP: begin
            if (fill == 0) begin
               r.status = is_closed ? dorf_pkg::STAT_CLOSED : dorf_pkg::STAT_EMPTY;
            end else begin
               r.word = ring[head_ptr];
               head_ptr = next_slot(head_ptr);
               fill--;
            end
         end
         dorf_pkg::CMD_CLOSE: begin
            is_closed = 1'b1;
         end
         default: ;
      endcase
      r.occupancy = OCC_W'(fill);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         head_ptr    = 0;
         tail_ptr    = 0;
         fill        = 0;
         is_closed   = 1'b0;
         cap_limit   = clamp_cap(dorf_pkg::CAP_RESET);
         mismatches  = 0;
         pending_replies.delete();
         outstanding <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == CAP_ADDR) begin
            cap_limit = clamp_cap(csr_pwdata);
            head_ptr  = 0;
            tail_ptr  = 0;
            fill      = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status    = rsp_tuser;
            got.word      = rsp_tdata[WORD_W-1:0];
            got.occupancy = rsp_tdata[WORD_W +: OCC_W];
            if (pending_replies.size() == 0) begin
               $display("%0t: rsp beat with none expected: status %0d word %h occupancy %0d",
                        $time, got.status, got.word, got.occupancy);
               mismatches++;
            end else begin
               want = pending_replies.pop_front();
               if (got !== want) begin
                  $display("%0t: rsp mismatch: expected status %0d word %h occupancy %0d, %s",
                           $time, want.status, want.word, want.occupancy, "actual below");
                  $display("%0t:                actual   status %0d word %h occupancy %0d",
                           $time, got.status, got.word, got.occupancy);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_replies.push_back(apply_command(req_tuser, req_tdata[WORD_W-1:0]));
         outstanding <= pending_replies.size();
      end
   end

endmodule

// File: tb/tb_drop_oldest_ring_fifo.sv
`timescale 1ns / 100ps
// Top of the drop-oldest ring FIFO testbench: clock, reset, req/rsp/csr stimulus
// and the verdict. Depends on dorf_pkg, drop_oldest_ring_fifo and dorf_checker.
module tb_drop_oldest_ring_fifo;

   localparam int WORD_W  = dorf_pkg::WORD_WIDTH_DEFAULT;
   localparam int ADDR_W  = dorf_pkg::CSR_ADDR_W;
   localparam int DATA_W  = dorf_pkg::CSR_DATA_W;
   localparam int REQ_W   = ((WORD_W + 7) / 8) * 8;
   localparam int RSP_W   = ((WORD_W + $clog2(dorf_pkg::DEPTH_DEFAULT + 1) + 7) / 8) * 8;
   localparam logic [1:0] CMD_NOP = 2'd3;
   localparam logic [ADDR_W-1:0] CAP_ADDR = ADDR_W'(4 * dorf_pkg::REG_CAPACITY);
   localparam int LONG_HOLD         = 300;
   localparam int CYCLE_LIMIT       = 200000;
   localparam int SEGMENTS_PER_MODE = 4;
   localparam int SEGMENT_BEATS     = 120;
   localparam int CLOSED_BEATS      = 100;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;   // item_value
   logic [1:0]            req_tuser;   // command
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_W-1:0]      rsp_tdata;   // item_out, occupancy
   logic [1:0]            rsp_tuser;   // status
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [ADDR_W-1:0]     csr_paddr;
   logic [DATA_W-1:0]     csr_pwdata;
   logic [DATA_W-1:0]     csr_prdata;
   logic                  csr_pready;

   int unsigned outstanding;
   int unsigned mismatches;
   int unsigned req_gap_pct;
   int unsigned rsp_gap_pct;
   int unsigned hold_asks;
   int unsigned hold_served;
   int unsigned cycle_count;

   drop_oldest_ring_fifo uut (.*);

   dorf_checker fifo_watch (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      hold_served = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rsp_gap_pct);
      end
   end

   task automatic send_beat(input logic [1:0] cmd, input logic [WORD_W-1:0] value);
      while (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_W'(value);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAP_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      int unsigned seg;
      int unsigned sent;
      int unsigned burst;
      int unsigned push_pct;
      int unsigned pick;
      logic [1:0]  cmd;
      logic [DATA_W-1:0] cap_value;

      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= dorf_pkg::CMD_PUSH;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CAP_ADDR;
      csr_pwdata  <= '0;
      req_gap_pct = 0;
      rsp_gap_pct = 0;
      hold_asks   = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty pop, no-op, extreme words at reset capacity
      send_beat(dorf_pkg::CMD_POP, 32'h1234_5678);
      send_beat(CMD_NOP, 32'hFFFF_FFFF);
      send_beat(dorf_pkg::CMD_PUSH, 32'h0000_0000);
      send_beat(dorf_pkg::CMD_PUSH, 32'hFFFF_FFFF);
      send_beat(dorf_pkg::CMD_POP, 32'h0);
      send_beat(dorf_pkg::CMD_POP, 32'h0);
      drain_replies();

      // zero capacity acts as one: second push drops the first
      write_capacity(32'd0);
      send_beat(dorf_pkg::CMD_PUSH, 32'hA5A5_A5A5);
      send_beat(dorf_pkg::CMD_PUSH, 32'h5A5A_5A5A);
      send_beat(dorf_pkg::CMD_POP, 32'h0);
      drain_replies();

      // wrap around a three-entry ring with a drop
      write_capacity(32'd3);
      send_beat(dorf_pkg::CMD_PUSH, 32'h0000_0001);
      send_beat(dorf_pkg::CMD_PUSH, 32'h0000_0002);
      send_beat(dorf_pkg::CMD_PUSH, 32'h0000_0003);
      send_beat(dorf_pkg::CMD_PUSH, 32'h0000_0004);
      send_beat(dorf_pkg::CMD_POP, 32'h0);
      send_beat(dorf_pkg::CMD_POP, 32'h0);
      send_beat(dorf_pkg::CMD_POP, 32'h0);
      send_beat(dorf_pkg::CMD_POP, 32'h0);
      drain_replies();

      // oversize capacity clamps; a capacity write empties a non-empty FIFO
      write_capacity(32'd31);
      send_beat(dorf_pkg::CMD_PUSH, 32'hDEAD_BEEF);
      drain_replies();
      write_capacity(32'd16);
      send_beat(dorf_pkg::CMD_POP, 32'h0);

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               req_gap_pct = 16;
               rsp_gap_pct = 64;
            end
            1: begin
               req_gap_pct = 64;
               rsp_gap_pct = 16;
            end
            default: begin
               req_gap_pct = 0;
               rsp_gap_pct = 0;
            end
         endcase
         for (int s = 0; s < SEGMENTS_PER_MODE; s++) begin
            seg = mode * SEGMENTS_PER_MODE + s;
            drain_replies();
            case (seg)
               0: cap_value = 32'd16;
               1: cap_value = 32'd1;
               2: cap_value = 32'd2;
               3: cap_value = 32'd31;
               4: cap_value = 32'd0;
               5: cap_value = 32'd17;
               default: begin
                  cap_value = $urandom_range(31);
                  if ($urandom_range(3) == 0)
                     cap_value = cap_value | ($urandom() & 32'hFFFF_FFE0);
               end
            endcase
            write_capacity(cap_value);
            // stall the rsp side so the block backs up into req
            if (seg == 0)
               hold_asks++;
            sent = 0;
            while (sent < SEGMENT_BEATS) begin
               push_pct = $urandom_range(10, 90);
               burst    = $urandom_range(4, 40);
               repeat (burst) begin
                  pick = $urandom_range(99);
                  if (pick < 2)
                     cmd = CMD_NOP;
                  else if (pick < push_pct)
                     cmd = dorf_pkg::CMD_PUSH;
                  else
                     cmd = dorf_pkg::CMD_POP;
                  send_beat(cmd, $urandom());
               end
               sent += burst;
            end
         end
      end

      // closed behavior: refused push, drain, empty-closed pop, repeat close
      drain_replies();
      write_capacity(32'd4);
      send_beat(dorf_pkg::CMD_PUSH, 32'h1111_1111);
      send_beat(dorf_pkg::CMD_PUSH, 32'h2222_2222);
      send_beat(dorf_pkg::CMD_CLOSE, 32'hFFFF_FFFF);
      send_beat(dorf_pkg::CMD_PUSH, 32'h3333_3333);
      send_beat(dorf_pkg::CMD_POP, 32'h0);
      send_beat(dorf_pkg::CMD_POP, 32'h0);
      send_beat(dorf_pkg::CMD_POP, 32'h0);
      send_beat(dorf_pkg::CMD_CLOSE, 32'h0);
      send_beat(CMD_NOP, 32'h0);
      drain_replies();
      write_capacity(32'd16);
      send_beat(dorf_pkg::CMD_PUSH, 32'h4444_4444);
      req_gap_pct = 16;
      rsp_gap_pct = 16;
      repeat (CLOSED_BEATS) begin
         cmd = 2'($urandom_range(3));
         send_beat(cmd, $urandom());
      end

      drain_replies();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
